// ----- src/e2q_pkg.sv -----
// Package for the Euler-to-quaternion block: widths, CORDIC constants, arctangent table.
// Used by e2q_cell, e2q_prod and euler_to_quaternion.
`default_nettype none
package e2q_pkg;
  localparam int unsigned AngleW = 16;
  localparam int unsigned QuatW = 16;
  localparam int unsigned CordW = 34;    // Q30 vector with growth margin
  localparam int unsigned ZW = 34;       // pi = 2^31, plus sign and margin
  localparam int unsigned TrigW = 17;    // Q15 sine/cosine, sign included
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned CordicStagesDef = 16;
  localparam logic signed [CordW-1:0] CordicGain = 34'sh026DD3B6A;
  localparam logic signed [QuatW-1:0] Q14One = 16'sd16384;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [ZW-1:0] zang_t;
  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    cord_t x;
    cord_t y;
    zang_t z;
  } rot_t;

  function automatic zang_t atan_step(input int unsigned i);
    zang_t r;
    r = '0;
    unique case (i)
      0: r = 34'sh020000000;
      1: r = 34'sh012E4051E;
      2: r = 34'sh009FB385B;
      3: r = 34'sh0051111D4;
      4: r = 34'sh0028B0D43;
      5: r = 34'sh00145D7E1;
      6: r = 34'sh000A2F61E;
      7: r = 34'sh000517C55;
      8: r = 34'sh00028BE53;
      9: r = 34'sh000145F2F;
      10: r = 34'sh0000A2F98;
      11: r = 34'sh0000517CC;
      12: r = 34'sh000028BE6;
      13: r = 34'sh0000145F3;
      14: r = 34'sh00000A2F9;
      15: r = 34'sh00000517C;
      16: r = 34'sh0000028BE;
      17: r = 34'sh00000145F;
      18: r = 34'sh000000A2F;
      19: r = 34'sh000000517;
      20: r = 34'sh00000028B;
      21: r = 34'sh000000145;
      22: r = 34'sh0000000A2;
      23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- src/e2q_cell.sv -----
// One CORDIC rotation cell: three lanes (x, y, z angles) advance one micro-rotation.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cell import e2q_pkg::*; #(
  parameter int unsigned Stage = 0
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire logic    valid_i,
  input  wire rot_t [2:0] rot_i,
  output logic         valid_o,
  output rot_t [2:0]   rot_o
);
  rot_t [2:0] rot_d, rot_q;
  logic valid_q;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (rot_i[l].z >= 0) begin
        rot_d[l].x = rot_i[l].x - (rot_i[l].y >>> Stage);
        rot_d[l].y = rot_i[l].y + (rot_i[l].x >>> Stage);
        rot_d[l].z = rot_i[l].z - atan_step(Stage);
      end else begin
        rot_d[l].x = rot_i[l].x + (rot_i[l].y >>> Stage);
        rot_d[l].y = rot_i[l].y - (rot_i[l].x >>> Stage);
        rot_d[l].z = rot_i[l].z + atan_step(Stage);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q <= rot_d;
    end
  end

  assign valid_o = valid_q;
  assign rot_o = rot_q;
endmodule
`default_nettype wire

// ----- src/e2q_prod.sv -----
// Product stage: rounds CORDIC outputs to Q15, forms triple products, rounds to Q14.
// Depends on e2q_pkg.
`default_nettype none
module e2q_prod import e2q_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  wire logic       valid_i,
  input  wire rot_t [2:0] rot_i,
  output logic            valid_o,
  output logic signed [QuatW-1:0] quat_o [4]
);
  localparam int unsigned PairW = 2 * TrigW;
  localparam int unsigned TripW = 3 * TrigW + 1;

  trig_t c_d [3], s_d [3];
  trig_t c_q [3], s_q [3];
  logic signed [PairW-1:0] cc_d, cs_d, sc_d, ss_d;
  logic signed [PairW-1:0] cc_q, cs_q, sc_q, ss_q;
  trig_t cx_q, sx_q;
  logic signed [TripW-1:0] sum_d [4];
  logic signed [TripW-1:0] sum_q [4];
  logic signed [QuatW-1:0] quat_d [4];
  logic signed [QuatW-1:0] quat_q [4];
  logic [3:0] v_q;

  // round Q30 to Q15
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      cord_t tc, ts;
      tc = rot_i[l].x + cord_t'(1 <<< 14);
      ts = rot_i[l].y + cord_t'(1 <<< 14);
      c_d[l] = trig_t'(tc >>> 15);
      s_d[l] = trig_t'(ts >>> 15);
    end
  end

  // y and z pair products
  always_comb begin
    cc_d = PairW'(c_q[1] * c_q[2]);
    cs_d = PairW'(c_q[1] * s_q[2]);
    sc_d = PairW'(s_q[1] * c_q[2]);
    ss_d = PairW'(s_q[1] * s_q[2]);
  end

  always_comb begin
    logic signed [TripW-1:0] a, b;
    a = TripW'(sx_q * cc_q); b = TripW'(cx_q * ss_q); sum_d[0] = a + b;
    a = TripW'(cx_q * sc_q); b = TripW'(sx_q * cs_q); sum_d[1] = a - b;
    a = TripW'(cx_q * cs_q); b = TripW'(sx_q * sc_q); sum_d[2] = a + b;
    a = TripW'(cx_q * cc_q); b = TripW'(sx_q * ss_q); sum_d[3] = a - b;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic signed [TripW-1:0] r;
      r = (sum_q[k] + TripW'(64'sd1 <<< 30)) >>> 31;
      if (r > TripW'(Q14One)) begin
        quat_d[k] = Q14One;
      end else if (r < -TripW'(Q14One)) begin
        quat_d[k] = -Q14One;
      end else begin
        quat_d[k] = QuatW'(r);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
      s_q <= s_d;
      cc_q <= cc_d;
      cs_q <= cs_d;
      sc_q <= sc_d;
      ss_q <= ss_d;
      cx_q <= c_q[0];
      sx_q <= s_q[0];
      sum_q <= sum_d;
      quat_q <= quat_d;
    end
  end

  assign valid_o = v_q[3];
  assign quat_o = quat_q;
endmodule
`default_nettype wire

// ----- src/euler_to_quaternion.sv -----
// Top level of the Euler-to-quaternion block: CORDIC cell chain, product stage, output skid.
// Depends on e2q_pkg, e2q_cell and e2q_prod.
//
// Accepts one angle triple per cycle while stall_o is low and returns quat_x/y/z/w
// in Q2.14. There are min(CORDIC_STAGES, 24) cells, one per CORDIC micro-rotation, then
// four product/rounding registers, then the output register. The pipeline advances whenever
// the skid entry is empty; the output register plus one skid entry keep input stall
// registered, so input stall is high only when the skid holds a waiting word.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CordicStagesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  output logic      stall_o,
  input  wire logic signed [AngleW-1:0] angle_x_i,
  input  wire logic signed [AngleW-1:0] angle_y_i,
  input  wire logic signed [AngleW-1:0] angle_z_i,
  output logic      valid_o,
  input  wire logic stall_i,
  output logic signed [QuatW-1:0] quat_x_o,
  output logic signed [QuatW-1:0] quat_y_o,
  output logic signed [QuatW-1:0] quat_z_o,
  output logic signed [QuatW-1:0] quat_w_o
);
  localparam int unsigned NCells = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

  logic en;
  logic v_chain [NCells+1];
  rot_t [2:0] r_chain [NCells+1];
  logic p_valid;
  logic signed [QuatW-1:0] p_quat [4];

  assign v_chain[0] = valid_i;
  assign r_chain[0][0] = '{x: CordicGain, y: '0, z: zang_t'(angle_x_i) <<< 15};
  assign r_chain[0][1] = '{x: CordicGain, y: '0, z: zang_t'(angle_y_i) <<< 15};
  assign r_chain[0][2] = '{x: CordicGain, y: '0, z: zang_t'(angle_z_i) <<< 15};

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    e2q_cell #(.Stage(g)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v_chain[g]), .rot_i(r_chain[g]),
      .valid_o(v_chain[g+1]), .rot_o(r_chain[g+1])
    );
  end

  e2q_prod u_prod (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_chain[NCells]), .rot_i(r_chain[NCells]),
    .valid_o(p_valid), .quat_o(p_quat)
  );

  // output register plus skid entry
  logic out_v_q, skid_v_q;
  logic signed [QuatW-1:0] out_q [4];
  logic signed [QuatW-1:0] skid_q [4];

  // advance while skid is empty; a word landing while output stalls goes to skid
  assign en = !skid_v_q;
  assign stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || !stall_i) begin
        if (skid_v_q) begin
          out_v_q <= 1'b1;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= p_valid;
        end
      end else if (en && p_valid) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || !stall_i) begin
      out_q <= skid_v_q ? skid_q : p_quat;
    end else if (en && p_valid) begin
      skid_q <= p_quat;
    end
  end

  assign valid_o = out_v_q;
  assign quat_x_o = out_q[0];
  assign quat_y_o = out_q[1];
  assign quat_z_o = out_q[2];
  assign quat_w_o = out_q[3];
endmodule
`default_nettype wire
